// ----- src/handle_slot_allocator_defines.svh -----
// assertion macros used by the handle slot allocator checker
// no dependencies; the checker provides clk_i and rst_ni in scope
`ifndef HANDLE_SLOT_ALLOCATOR_DEFINES_SVH
`define HANDLE_SLOT_ALLOCATOR_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define HSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked in the cycle after the antecedent
`define HSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

// ----- src/hsa_pkg.sv -----
// types and constants for the handle slot allocator
// no dependencies
package hsa_pkg;

  localparam int unsigned HandleW = 48;
  localparam int unsigned SlotW   = 8;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NULL     = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [SlotW-1:0]   slot_index;
    logic [HandleW-1:0] object_handle;
    logic [HandleW-1:0] binding_handle;
  } hsa_req_t;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot_out;
    logic [HandleW-1:0] object_out;
    logic [HandleW-1:0] binding_out;
  } hsa_rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } hsa_stack_ctl_t;

endpackage

// ----- src/hsa_free_stack.sv -----
// lifo stack of freed slot numbers with a prefetched top entry
// depends on hsa_pkg
module hsa_free_stack #(
  parameter int unsigned SLOTS = 256,
  localparam int unsigned AddrW = $clog2(SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsa_pkg::hsa_stack_ctl_t ctl_i,
  input  logic [AddrW-1:0]      push_slot_i,
  output logic [AddrW-1:0]      top_o,
  output logic [AddrW:0]        count_o
);
  import hsa_pkg::*;

  logic [AddrW-1:0] stack_mem [SLOTS];
  logic [AddrW:0]   count_q, count_d;
  logic [AddrW-1:0] top_q;
  logic [AddrW-1:0] wr_addr, rd_addr;

  always_comb begin
    count_d = count_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.push) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  assign wr_addr = count_q[AddrW-1:0];
  assign rd_addr = AddrW'(count_d - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // top always tracks entry count_q - 1, forwarded from a push
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      stack_mem[wr_addr] <= push_slot_i;
    end
    if (ctl_i.push && wr_addr == rd_addr) begin
      top_q <= push_slot_i;
    end else begin
      top_q <= stack_mem[rd_addr];
    end
  end

  assign top_o   = top_q;
  assign count_o = count_q;

endmodule

// ----- src/handle_slot_allocator.sv -----
// handle slot allocator top level: request register, slot stores, result register
// depends on hsa_pkg and hsa_free_stack
//
// Takes one request per clock while the output is not stalled and gives one result per
// request, in order. A request is registered on acceptance while the slot stores are
// read at its slot_index; when the request register can move on, the decision is made
// and the result is loaded into the output register. The throughput of one request per
// cycle, when the output is not stalled, is set by the single write and single read port
// of the slot stores, with the write of the request ahead forwarded to the read of the
// next one, and by the free stack whose top entry is fetched ahead. A stalled output
// holds the request register and, through it, the input. Slots run from 1 to SLOTS-1;
// no clearing pass is needed after reset or clear because only slots below the fresh
// pointer, all written by an allocate, are ever looked at.
module handle_slot_allocator #(
  parameter int unsigned SLOTS       = 256,
  parameter int unsigned HANDLE_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsa_pkg::hsa_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsa_pkg::hsa_rsp_t out_rsp_o
);
  import hsa_pkg::*;

  localparam int unsigned AddrW  = $clog2(SLOTS);
  localparam int unsigned CntW   = AddrW + 1;
  localparam int unsigned StoreW = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;

  logic              in_fire, a_fire;
  logic              a_valid_q;
  hsa_req_t          a_req_q;
  logic              out_valid_q;
  hsa_rsp_t          rsp_q, rsp_d;

  logic [StoreW-1:0] obj_mem  [SLOTS];
  logic [StoreW-1:0] bind_mem [SLOTS];
  logic [StoreW-1:0] rd_obj_q, rd_bind_q;
  logic [AddrW-1:0]  rd_addr;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [StoreW-1:0] wr_obj, wr_bind;

  logic [CntW-1:0]   fresh_q, fresh_d;

  hsa_stack_ctl_t    stk_ctl;
  logic [AddrW-1:0]  stk_push_slot, stk_top;
  logic [CntW-1:0]   stk_count;

  logic [StoreW-1:0] a_obj, a_bind;
  logic [SlotW-1:0]  a_slot;
  logic              slot_live;

  hsa_free_stack #(
    .SLOTS(SLOTS)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (stk_ctl),
    .push_slot_i(stk_push_slot),
    .top_o      (stk_top),
    .count_o    (stk_count)
  );

  assign a_fire     = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_addr    = AddrW'(in_req_i.slot_index);

  assign a_obj     = a_req_q.object_handle[StoreW-1:0];
  assign a_bind    = a_req_q.binding_handle[StoreW-1:0];
  assign a_slot    = a_req_q.slot_index;
  assign slot_live = (a_slot != '0) && (32'(a_slot) < 32'(fresh_q)) && (rd_obj_q != '0);

  always_comb begin
    rsp_d         = '0;
    rsp_d.status  = ST_OK;
    wr_en         = 1'b0;
    wr_addr       = AddrW'(a_slot);
    wr_obj        = '0;
    wr_bind       = '0;
    fresh_d       = fresh_q;
    stk_ctl       = '0;
    stk_push_slot = AddrW'(a_slot);
    case (a_req_q.req_type)
      REQ_ALLOC: begin
        if (a_obj == '0 || a_bind == '0) begin
          rsp_d.status = ST_NULL;
        end else if (stk_count != '0) begin
          stk_ctl.pop    = 1'b1;
          wr_en          = 1'b1;
          wr_addr        = stk_top;
          rsp_d.slot_out = SlotW'(stk_top);
        end else if (32'(fresh_q) < SLOTS) begin
          fresh_d        = fresh_q + 1'b1;
          wr_en          = 1'b1;
          wr_addr        = AddrW'(fresh_q);
          rsp_d.slot_out = SlotW'(fresh_q);
        end else begin
          rsp_d.status = ST_FULL;
        end
        wr_obj  = a_obj;
        wr_bind = a_bind;
      end
      REQ_FREE: begin
        rsp_d.slot_out = a_slot;
        if (!slot_live || 32'(stk_count) >= SLOTS) begin
          rsp_d.status = ST_BAD_SLOT;
        end else begin
          wr_en        = 1'b1;
          stk_ctl.push = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        rsp_d.slot_out = a_slot;
        if (!slot_live) begin
          rsp_d.status = ST_BAD_SLOT;
        end else begin
          rsp_d.object_out  = HandleW'(rd_obj_q);
          rsp_d.binding_out = HandleW'(rd_bind_q);
        end
      end
      REQ_CLEAR: begin
        stk_ctl.clear = 1'b1;
        fresh_d       = CntW'(1);
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
    if (!a_fire) begin
      wr_en   = 1'b0;
      stk_ctl = '0;
      fresh_d = fresh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fresh_q     <= CntW'(1);
    end else begin
      fresh_q <= fresh_d;
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (a_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_req_q <= in_req_i;
    end
    if (a_fire) begin
      rsp_q <= rsp_d;
    end
  end

  // slot stores, read forwarded from the write of the request ahead
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      obj_mem[wr_addr]  <= wr_obj;
      bind_mem[wr_addr] <= wr_bind;
    end
    if (in_fire) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_obj_q  <= wr_obj;
        rd_bind_q <= wr_bind;
      end else begin
        rd_obj_q  <= obj_mem[rd_addr];
        rd_bind_q <= bind_mem[rd_addr];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- src/hsa_checker.sv -----
// port-level checks for the handle slot allocator, bound to the top level
// depends on hsa_pkg and handle_slot_allocator_defines.svh
`include "handle_slot_allocator_defines.svh"

module hsa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input hsa_pkg::hsa_rsp_t out_rsp_o
);
  import hsa_pkg::*;

  `HSA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "result changed while stalled")
  `HSA_ASSERT(a_fail_no_slot, out_valid_o && (out_rsp_o.status == ST_NULL || out_rsp_o.status == ST_FULL) |-> out_rsp_o.slot_out == '0, "failed allocate granted a slot")
  `HSA_ASSERT(a_fail_no_handles, out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.object_out == '0 && out_rsp_o.binding_out == '0, "handles shown on a failed request")
  `HSA_ASSERT(a_lookup_shape, out_valid_o && out_rsp_o.object_out != '0 |-> out_rsp_o.slot_out != '0 && out_rsp_o.binding_out != '0, "lookup result from slot zero or with null binding")

endmodule

bind handle_slot_allocator hsa_checker u_hsa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);
